// ===== rtl/core/isw_pkg.sv =====
// Shared types and constants for the interval stopwatch statistics block.
package isw_pkg;

    // Field widths of the stream items
    localparam int unsigned STAMP_SEC_W  = 32;
    localparam int unsigned NSEC_W       = 30;
    localparam int unsigned COUNT_W      = 32;
    localparam int unsigned SEC_WIDTH_DEF = 32;

    // Packed stream widths (whole bytes)
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 224;

    // Nanosecond arithmetic constants
    localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [NSEC_W-1:0] NS_MAX     = 30'd999999999;

    // Event opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STOP  = 1'b1;

    // One input event
    typedef struct packed {
        logic                   opcode;
        logic [STAMP_SEC_W-1:0] stamp_sec;
        logic [NSEC_W-1:0]      stamp_nsec;
    } t_item;

    // One result: running flag and all statistics
    typedef struct packed {
        logic                   running;
        logic [STAMP_SEC_W-1:0] total_sec;
        logic [NSEC_W-1:0]      total_nsec;
        logic [STAMP_SEC_W-1:0] min_sec;
        logic [NSEC_W-1:0]      min_nsec;
        logic [STAMP_SEC_W-1:0] max_sec;
        logic [NSEC_W-1:0]      max_nsec;
        logic [COUNT_W-1:0]     start_count;
    } t_result;

endpackage

// ===== rtl/core/isw_in_reg.sv =====
// Input register stage: captures one event request and holds it until it moves on.
module isw_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  isw_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output isw_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    isw_pkg::t_item r_item;

    // Accept when empty or when the held request moves on this cycle
    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/isw_core.sv =====
// Stopwatch state registers and the combinational interval/statistics update.
module isw_core #(
    parameter int unsigned SEC_WIDTH = isw_pkg::SEC_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  isw_pkg::t_item   i_item,
    output isw_pkg::t_result o_result
);

    localparam int unsigned NW    = isw_pkg::NSEC_W;
    localparam int unsigned SW    = SEC_WIDTH;
    localparam int unsigned EXT_W = (SW > isw_pkg::STAMP_SEC_W) ? SW : isw_pkg::STAMP_SEC_W;

    logic                            r_running, n_running;
    logic [SW-1:0]                   r_begin_sec, n_begin_sec;
    logic [NW-1:0]                   r_begin_nsec, n_begin_nsec;
    logic [SW-1:0]                   r_sum_sec, n_sum_sec;
    logic [NW-1:0]                   r_sum_nsec, n_sum_nsec;
    logic [SW-1:0]                   r_least_sec, n_least_sec;
    logic [NW-1:0]                   r_least_nsec, n_least_nsec;
    logic [SW-1:0]                   r_most_sec, n_most_sec;
    logic [NW-1:0]                   r_most_nsec, n_most_nsec;
    logic [isw_pkg::COUNT_W-1:0]     r_starts, n_starts;

    logic [EXT_W-1:0] stamp_ext;
    logic [SW-1:0]    now_sec;
    logic [NW-1:0]    now_nsec;
    logic             borrow;
    logic [SW-1:0]    dsec;
    logic [NW-1:0]    dnsec;
    logic [NW:0]      nsum;
    logic             carry;
    logic             close_iv;
    logic             least_upd;
    logic             most_upd;

    // Event time: seconds modulo 2^SEC_WIDTH, nanoseconds saturated
    assign stamp_ext = EXT_W'(i_item.stamp_sec);
    assign now_sec   = stamp_ext[SW-1:0];
    assign now_nsec  = (i_item.stamp_nsec > isw_pkg::NS_MAX) ? isw_pkg::NS_MAX
                                                             : i_item.stamp_nsec;

    // Interval length with nanosecond borrow
    assign borrow = now_nsec < r_begin_nsec;
    assign dsec   = now_sec - r_begin_sec - SW'(borrow);
    assign dnsec  = now_nsec - r_begin_nsec + (borrow ? isw_pkg::NS_PER_SEC : '0);

    // Running total with nanosecond carry
    assign nsum  = {1'b0, r_sum_nsec} + {1'b0, dnsec};
    assign carry = nsum >= {1'b0, isw_pkg::NS_PER_SEC};

    // Min/max compare; a zero minimum means unset
    assign least_upd = ({r_least_sec, r_least_nsec} > {dsec, dnsec}) ||
                       ((r_least_sec == '0) && (r_least_nsec == '0));
    assign most_upd  = {r_most_sec, r_most_nsec} < {dsec, dnsec};

    // Any event while running closes the open interval
    assign close_iv = r_running;

    always_comb begin
        n_running    = r_running;
        n_begin_sec  = r_begin_sec;
        n_begin_nsec = r_begin_nsec;
        n_sum_sec    = r_sum_sec;
        n_sum_nsec   = r_sum_nsec;
        n_least_sec  = r_least_sec;
        n_least_nsec = r_least_nsec;
        n_most_sec   = r_most_sec;
        n_most_nsec  = r_most_nsec;
        n_starts     = r_starts;

        if (close_iv) begin
            n_sum_sec  = r_sum_sec + dsec + SW'(carry);
            n_sum_nsec = carry ? NW'(nsum - {1'b0, isw_pkg::NS_PER_SEC}) : nsum[NW-1:0];
            if (least_upd) begin
                n_least_sec  = dsec;
                n_least_nsec = dnsec;
            end
            if (most_upd) begin
                n_most_sec  = dsec;
                n_most_nsec = dnsec;
            end
        end

        if (i_item.opcode == isw_pkg::OP_START) begin
            n_begin_sec  = now_sec;
            n_begin_nsec = now_nsec;
            n_running    = 1'b1;
            n_starts     = r_starts + isw_pkg::COUNT_W'(1);
        end else if (r_running) begin
            n_begin_sec  = '0;
            n_begin_nsec = '0;
            n_running    = 1'b0;
        end
    end

    // State registers update once per accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_begin_sec  <= '0;
            r_begin_nsec <= '0;
            r_sum_sec    <= '0;
            r_sum_nsec   <= '0;
            r_least_sec  <= '0;
            r_least_nsec <= '0;
            r_most_sec   <= '0;
            r_most_nsec  <= '0;
            r_starts     <= '0;
        end else if (i_fire) begin
            r_running    <= n_running;
            r_begin_sec  <= n_begin_sec;
            r_begin_nsec <= n_begin_nsec;
            r_sum_sec    <= n_sum_sec;
            r_sum_nsec   <= n_sum_nsec;
            r_least_sec  <= n_least_sec;
            r_least_nsec <= n_least_nsec;
            r_most_sec   <= n_most_sec;
            r_most_nsec  <= n_most_nsec;
            r_starts     <= n_starts;
        end
    end

    // Result view of the post-event state, seconds sized to the port width
    logic [EXT_W-1:0] sum_ext, least_ext, most_ext;

    assign sum_ext   = EXT_W'(n_sum_sec);
    assign least_ext = EXT_W'(n_least_sec);
    assign most_ext  = EXT_W'(n_most_sec);

    assign o_result.running     = n_running;
    assign o_result.total_sec   = sum_ext[isw_pkg::STAMP_SEC_W-1:0];
    assign o_result.total_nsec  = n_sum_nsec;
    assign o_result.min_sec     = least_ext[isw_pkg::STAMP_SEC_W-1:0];
    assign o_result.min_nsec    = n_least_nsec;
    assign o_result.max_sec     = most_ext[isw_pkg::STAMP_SEC_W-1:0];
    assign o_result.max_nsec    = n_most_nsec;
    assign o_result.start_count = n_starts;

endmodule

// ===== rtl/core/isw_out_reg.sv =====
// Output register stage: holds one result request until the sink takes it.
module isw_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  isw_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output isw_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    isw_pkg::t_result r_result;

    // Free when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/interval_stopwatch_statistics_top.sv =====
// Interval stopwatch statistics: start/stop events in, running flag and statistics out.
// An accepted event waits in the input register until the result register is free.
// Throughput: one event per cycle while the sink takes results; the state update is
// a single pass from the input register to the result register through the interval
// and total adders.
// Reset (synchronous, active low) empties both stages and clears the stopwatch
// to stopped with zero totals, minimum, maximum and start count.
module interval_stopwatch_statistics_top #(
    parameter int unsigned SEC_WIDTH = isw_pkg::SEC_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] stamp_sec, [61:32] stamp_nsec, [63:62] zero
    input  logic [isw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] opcode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] running, [32:1] total_sec, [62:33] total_nsec, [94:63] min_sec,
    // [124:95] min_nsec, [156:125] max_sec, [186:157] max_nsec,
    // [218:187] start_count, [223:219] zero
    output logic [isw_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int unsigned SW = isw_pkg::STAMP_SEC_W;
    localparam int unsigned NW = isw_pkg::NSEC_W;

    isw_pkg::t_item   in_item;
    isw_pkg::t_item   held_item;
    isw_pkg::t_result core_result;
    isw_pkg::t_result out_result;
    logic             held_valid;
    logic             out_free;
    logic             advance;

    // Unpack the incoming request
    assign in_item.opcode     = s_axis_tuser;
    assign in_item.stamp_sec  = s_axis_tdata[SW-1:0];
    assign in_item.stamp_nsec = s_axis_tdata[SW+NW-1:SW];

    // A held event moves to the result register when that register is free
    assign advance = held_valid && out_free;

    isw_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    isw_core #(
        .SEC_WIDTH (SEC_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (held_item),
        .o_result (core_result)
    );

    isw_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result)
    );

    // Pack the result, lowest field first, zero fill to a whole byte
    assign m_axis_tdata = {5'd0,
                           out_result.start_count,
                           out_result.max_nsec,
                           out_result.max_sec,
                           out_result.min_nsec,
                           out_result.min_sec,
                           out_result.total_nsec,
                           out_result.total_sec,
                           out_result.running};

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the interval stopwatch statistics block.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned PHASE_EVENTS = 300;

    // One directed request, with an optional typed-in expected result
    typedef struct packed {
        logic             op;
        logic [31:0]      sec;
        logic [29:0]      nsec;
        logic             typed;
        isw_pkg::t_result want;
    } t_plan_row;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [31:0] stamp_sec, [61:32] stamp_nsec, [63:62] zero
    logic [63:0]  s_axis_tdata  = '0;
    // [0] opcode
    logic         s_axis_tuser  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [0] running, [32:1] total_sec, [62:33] total_nsec, [94:63] min_sec,
    // [124:95] min_nsec, [156:125] max_sec, [186:157] max_nsec,
    // [218:187] start_count, [223:219] zero
    logic [223:0] m_axis_tdata;

    // Predictor state
    logic        sw_running;
    logic [31:0] sw_begin_sec;
    logic [29:0] sw_begin_nsec;
    logic [31:0] sw_sum_sec;
    logic [29:0] sw_sum_nsec;
    logic [31:0] sw_least_sec;
    logic [29:0] sw_least_nsec;
    logic [31:0] sw_most_sec;
    logic [29:0] sw_most_nsec;
    logic [31:0] sw_starts;

    isw_pkg::t_result pending_stats[$];
    t_plan_row        dir_plan[$];

    // Stimulus time base for well-formed sequences
    logic [31:0] tnow_sec;
    logic [29:0] tnow_nsec;

    int unsigned src_idle   = 0;
    int unsigned sink_stall = 0;
    int unsigned cycles     = 0;
    int unsigned fail_count = 0;
    int unsigned events_sent, intervals_closed, idle_stops, clamped_stamps, results_checked;

    interval_stopwatch_statistics_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Close the open interval into total, minimum and maximum
    function automatic void close_interval(logic [31:0] now_s, logic [29:0] now_n);
        logic [31:0]  ds;
        int unsigned  dn;
        int unsigned  ns;
        if (now_n < sw_begin_nsec) begin
            ds = now_s - sw_begin_sec - 32'd1;
            dn = now_n + isw_pkg::NS_PER_SEC - sw_begin_nsec;
        end else begin
            ds = now_s - sw_begin_sec;
            dn = now_n - sw_begin_nsec;
        end
        ns = sw_sum_nsec + dn;
        if (ns >= isw_pkg::NS_PER_SEC) begin
            sw_sum_sec  = sw_sum_sec + ds + 32'd1;
            sw_sum_nsec = 30'(ns - isw_pkg::NS_PER_SEC);
        end else begin
            sw_sum_sec  = sw_sum_sec + ds;
            sw_sum_nsec = ns[29:0];
        end
        // a zero minimum means unset, so any interval replaces it
        if ({sw_least_sec, sw_least_nsec} > {ds, dn[29:0]} ||
            (sw_least_sec == '0 && sw_least_nsec == '0)) begin
            sw_least_sec  = ds;
            sw_least_nsec = dn[29:0];
        end
        if ({sw_most_sec, sw_most_nsec} < {ds, dn[29:0]}) begin
            sw_most_sec  = ds;
            sw_most_nsec = dn[29:0];
        end
        intervals_closed++;
    endfunction

    // Apply one event to the predicted stopwatch and report its statistics
    function automatic isw_pkg::t_result advance_stopwatch(logic op, logic [31:0] sec,
                                                           logic [29:0] nsec);
        logic [29:0]      now_n;
        isw_pkg::t_result r;
        now_n = (nsec > isw_pkg::NS_MAX) ? isw_pkg::NS_MAX : nsec;
        if (op == isw_pkg::OP_START) begin
            if (sw_running)
                close_interval(sec, now_n);
            sw_begin_sec  = sec;
            sw_begin_nsec = now_n;
            sw_running    = 1'b1;
            sw_starts     = sw_starts + 32'd1;
        end else if (sw_running) begin
            close_interval(sec, now_n);
            sw_begin_sec  = '0;
            sw_begin_nsec = '0;
            sw_running    = 1'b0;
        end else begin
            idle_stops++;
        end
        r.running     = sw_running;
        r.total_sec   = sw_sum_sec;
        r.total_nsec  = sw_sum_nsec;
        r.min_sec     = sw_least_sec;
        r.min_nsec    = sw_least_nsec;
        r.max_sec     = sw_most_sec;
        r.max_nsec    = sw_most_nsec;
        r.start_count = sw_starts;
        return r;
    endfunction

    function automatic isw_pkg::t_result stats(logic run, logic [31:0] tsec,
                                               logic [29:0] tnsec,
                                               logic [31:0] msec, logic [29:0] mnsec,
                                               logic [31:0] xsec, logic [29:0] xnsec,
                                               logic [31:0] cnt);
        isw_pkg::t_result r;
        r.running     = run;
        r.total_sec   = tsec;
        r.total_nsec  = tnsec;
        r.min_sec     = msec;
        r.min_nsec    = mnsec;
        r.max_sec     = xsec;
        r.max_nsec    = xnsec;
        r.start_count = cnt;
        return r;
    endfunction

    function automatic t_plan_row plan_row(logic op, logic [31:0] sec, logic [29:0] nsec,
                                           logic typed, isw_pkg::t_result want);
        t_plan_row p;
        p.op    = op;
        p.sec   = sec;
        p.nsec  = nsec;
        p.typed = typed;
        p.want  = want;
        return p;
    endfunction

    // Drive one request, wait for it to be taken, then queue its expectation
    task automatic send_event(input logic op, input logic [31:0] sec, input logic [29:0] nsec,
                              input logic typed, input isw_pkg::t_result want);
        isw_pkg::t_result predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, nsec, sec};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (nsec > isw_pkg::NS_MAX)
            clamped_stamps++;
        events_sent++;
        predicted = advance_stopwatch(op, sec, nsec);
        pending_stats.push_back(typed ? want : predicted);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge i_clk);
    endtask

    // Move the stimulus time base forward by a random amount
    task automatic advance_time();
        int unsigned dsec;
        int unsigned dns;
        int unsigned ns;
        dsec = 0;
        dns  = 0;
        case ($urandom_range(9))
            0: ;
            1, 2, 3, 4: dns = $urandom_range(1000, 1);
            5, 6, 7: begin
                dsec = $urandom_range(2);
                dns  = $urandom_range(999999999);
            end
            8: begin
                dsec = $urandom_range(1000);
                dns  = $urandom_range(999999999);
            end
            default: begin
                dsec = $urandom_range(32'h7FFF_FFFF);
                dns  = $urandom_range(999999999);
            end
        endcase
        ns = tnow_nsec + dns;
        if (ns >= isw_pkg::NS_PER_SEC) begin
            ns   = ns - isw_pkg::NS_PER_SEC;
            dsec = dsec + 1;
        end
        tnow_nsec = ns[29:0];
        tnow_sec  = tnow_sec + dsec;
    endtask

    // Mostly well-formed start/restart/stop sequences, some noise
    task automatic random_burst();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 5) begin
            tnow_sec  = $urandom;
            tnow_nsec = 30'($urandom_range(999999999));
        end
        if (kind < 85) begin
            send_event(isw_pkg::OP_START, tnow_sec, tnow_nsec, 1'b0, '0);
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(2, 1)) begin
                    advance_time();
                    send_event(isw_pkg::OP_START, tnow_sec, tnow_nsec, 1'b0, '0);
                end
            end
            advance_time();
            if ($urandom_range(9) != 0)
                send_event(isw_pkg::OP_STOP, tnow_sec, tnow_nsec, 1'b0, '0);
            advance_time();
        end else begin
            case ($urandom_range(3))
                // usually a stop while stopped
                0: send_event(isw_pkg::OP_STOP, tnow_sec, tnow_nsec, 1'b0, '0);
                // anywhere in the field ranges
                1: send_event(1'($urandom_range(1)), $urandom,
                              30'($urandom_range(30'h3FFF_FFFF)), 1'b0, '0);
                // nanoseconds beyond one second
                2: send_event(1'($urandom_range(1)), tnow_sec,
                              30'($urandom_range(30'h3FFF_FFFF, isw_pkg::NS_PER_SEC)),
                              1'b0, '0);
                // stamp earlier than the last one
                default: send_event(1'($urandom_range(1)), tnow_sec - $urandom_range(100),
                                    30'($urandom_range(999999999)), 1'b0, '0);
            endcase
        end
    endtask

    task automatic check_field(input string fname, input longint unsigned want,
                               input longint unsigned seen);
        if (want != seen) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, seen);
            fail_count++;
        end
    endtask

    // Result receiver
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall);

    // Result checker
    always @(posedge i_clk) begin
        isw_pkg::t_result seen;
        isw_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.running     = m_axis_tdata[0];
            seen.total_sec   = m_axis_tdata[32:1];
            seen.total_nsec  = m_axis_tdata[62:33];
            seen.min_sec     = m_axis_tdata[94:63];
            seen.min_nsec    = m_axis_tdata[124:95];
            seen.max_sec     = m_axis_tdata[156:125];
            seen.max_nsec    = m_axis_tdata[186:157];
            seen.start_count = m_axis_tdata[218:187];
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_stats.pop_front();
                check_field("running", want.running, seen.running);
                check_field("total_sec", want.total_sec, seen.total_sec);
                check_field("total_nsec", want.total_nsec, seen.total_nsec);
                check_field("min_sec", want.min_sec, seen.min_sec);
                check_field("min_nsec", want.min_nsec, seen.min_nsec);
                check_field("max_sec", want.max_sec, seen.max_sec);
                check_field("max_nsec", want.max_nsec, seen.max_nsec);
                check_field("start_count", want.start_count, seen.start_count);
                results_checked++;
            end
        end
    end

    // Main sequence
    initial begin
        int unsigned phase_start;
        sw_running    = 1'b0;
        sw_begin_sec  = '0;
        sw_begin_nsec = '0;
        sw_sum_sec    = '0;
        sw_sum_nsec   = '0;
        sw_least_sec  = '0;
        sw_least_nsec = '0;
        sw_most_sec   = '0;
        sw_most_nsec  = '0;
        sw_starts     = '0;
        tnow_sec      = $urandom;
        tnow_nsec     = 30'($urandom_range(999999999));
        events_sent = 0;
        intervals_closed = 0;
        idle_stops = 0;
        clamped_stamps = 0;
        results_checked = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset state, zero interval, borrow, clamping, wraps
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd0, 30'd0, 1'b1,
                                    stats(0, 0, 0, 0, 0, 0, 0, 0)));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'd0, 30'd0, 1'b1,
                                    stats(1, 0, 0, 0, 0, 0, 0, 1)));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd0, 30'd0, 1'b1,
                                    stats(0, 0, 0, 0, 0, 0, 0, 1)));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'd5, isw_pkg::NS_MAX, 1'b1,
                                    stats(1, 0, 0, 0, 0, 0, 0, 2)));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd7, 30'd1, 1'b1,
                                    stats(0, 1, 2, 1, 2, 1, 2, 2)));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd8, 30'd0, 1'b1,
                                    stats(0, 1, 2, 1, 2, 1, 2, 2)));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'd10, 30'h3FFF_FFFF, 1'b1,
                                    stats(1, 1, 2, 1, 2, 1, 2, 3)));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd10, isw_pkg::NS_MAX, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'd20, 30'd0, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'd25, 30'd500000000, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd30, 30'd0, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'hFFFF_FFFF, isw_pkg::NS_MAX,
                                    1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd0, 30'd0, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'd100, 30'd0, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd50, 30'd0, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'd0, 30'd0, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'hFFFF_FFFF, isw_pkg::NS_MAX,
                                    1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd1, 30'd1, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'd1000, 30'h3FFF_FFFF, 1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_START, 32'd1000, isw_pkg::NS_PER_SEC,
                                    1'b0, '0));
        dir_plan.push_back(plan_row(isw_pkg::OP_STOP, 32'd2000, 30'd0, 1'b0, '0));
        foreach (dir_plan[i])
            send_event(dir_plan[i].op, dir_plan[i].sec, dir_plan[i].nsec,
                       dir_plan[i].typed, dir_plan[i].want);
        drain_results();

        // Random part over four idle/stall settings
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 50; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 50; end
                default: begin src_idle = 31; sink_stall = 31; end
            endcase
            phase_start = events_sent;
            while (events_sent - phase_start < PHASE_EVENTS) begin
                random_burst();
                // in phase 2 the sender holds off mid-phase until the pipe is empty
                if (phase == 2 && events_sent - phase_start >= PHASE_EVENTS / 2 &&
                    events_sent - phase_start < PHASE_EVENTS / 2 + 4)
                    drain_results();
            end
        end

        drain_results();
        sink_stall = 0;
        repeat (10) @(posedge i_clk);
        if (pending_stats.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_stats.size());
            fail_count++;
        end

        $display("Sent %0d events: %0d intervals closed, %0d stops while stopped,",
                 events_sent, intervals_closed, idle_stops);
        $display("%0d clamped stamps; %0d results checked, %0d mismatches.",
                 clamped_stamps, results_checked, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
